// ----- rtl/core/bisc_pkg.sv -----
// Shared types and constants for the info dictionary span scanner.
`timescale 1ns / 1ps
`default_nettype none
package bisc_pkg;

    localparam int KeyLen = 6;
    localparam int KeyIdxW = 3;

    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_4     = 8'h34;  // '4'

    localparam logic [3:0] ST_SEARCH  = 4'd0;
    localparam logic [3:0] ST_INSIDE  = 4'd1;
    localparam logic [3:0] ST_DONE    = 4'd2;
    localparam logic [3:0] ST_NOKEY   = 4'd3;
    localparam logic [3:0] ST_NOTDICT = 4'd4;
    localparam logic [3:0] ST_BADSTR  = 4'd5;
    localparam logic [3:0] ST_BADINT  = 4'd6;
    localparam logic [3:0] ST_BADCHAR = 4'd7;
    localparam logic [3:0] ST_TRUNC   = 4'd8;
    localparam logic [3:0] ST_DEPTH   = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       in_span;
        logic       span_end;
        logic [3:0] status;
    } out_word_t;

    // key matcher to scan core
    typedef struct packed {
        logic [KeyIdxW-1:0] match_next;
        logic               hit;
    } key_t;

    // bytes of "4:info"
    function automatic logic [7:0] key_byte(input logic [KeyIdxW-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h34;  // '4'
            3'd1:    ch = 8'h3A;  // ':'
            3'd2:    ch = 8'h69;  // 'i'
            3'd3:    ch = 8'h6E;  // 'n'
            3'd4:    ch = 8'h66;  // 'f'
            3'd5:    ch = 8'h6F;  // 'o'
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bisc_key_det.sv -----
// Matcher for the six byte key that opens the info dictionary.
`timescale 1ns / 1ps
`default_nettype none
module bisc_key_det
    import bisc_pkg::*;
(
    input  wire logic [KeyIdxW-1:0] key_match,
    input  wire logic [7:0]         data_byte,
    output key_t                    key
);

    logic byte_hit;

    // index past the key never matches
    assign byte_hit = (key_match < KeyIdxW'(KeyLen))
                   && (data_byte == key_byte(key_match));

    always_comb
    begin
        if (byte_hit)
            key.match_next = key_match + KeyIdxW'(1);
        else if (data_byte == CH_4)
            key.match_next = KeyIdxW'(1);
        else
            key.match_next = '0;
        key.hit = byte_hit && (key_match == KeyIdxW'(KeyLen - 1));
    end

endmodule
`default_nettype wire

// ----- rtl/core/bisc_scan_core.sv -----
// Scan state, next-state logic and result word for one byte.
`timescale 1ns / 1ps
`default_nettype none
module bisc_scan_core
    import bisc_pkg::*;
#(
    parameter int LEN_BITS   = 32,
    parameter int DEPTH_BITS = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire in_word_t  word,
    output out_word_t      result
);

    localparam int AccW = LEN_BITS + 4;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_EXPECT_D,
        PH_STRUCT,
        PH_LEN,
        PH_LEN_SKIP,
        PH_BODY,
        PH_INT,
        PH_FINAL
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [KeyIdxW-1:0]    key_match_reg, key_match_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next, depth_dec;
    logic [LEN_BITS-1:0]   count_reg, count_next;
    logic [3:0]            status_reg, status_next, status_res;
    logic                  span, span_end, is_digit;
    logic [7:0]            b;
    logic [AccW-1:0]       acc;
    key_t                  key;

    assign b = word.data_byte;
    assign is_digit = b inside {[CH_0:CH_9]};
    assign depth_dec = depth_reg - DEPTH_BITS'(depth_reg != '0);
    // count * 10 + digit; overflow when the top nibble is set
    assign acc = ({4'b0, count_reg} << 3) + ({4'b0, count_reg} << 1) + AccW'(b[3:0]);

    bisc_key_det u_key_det (
        .key_match (key_match_reg),
        .data_byte (b),
        .key       (key)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        key_match_next = key_match_reg;
        depth_next     = depth_reg;
        count_next     = count_reg;
        status_res     = status_reg;
        span           = 1'b0;
        span_end       = 1'b0;

        case (phase_reg)
            PH_SEARCH:
            begin
                key_match_next = key.match_next;
                if (key.hit)
                begin
                    key_match_next = '0;
                    phase_next     = PH_EXPECT_D;
                end
            end
            PH_EXPECT_D:
            begin
                if (b == CH_D)
                begin
                    depth_next = DEPTH_BITS'(1);
                    phase_next = PH_STRUCT;
                    status_res = ST_INSIDE;
                    span       = 1'b1;
                end
                else
                begin
                    phase_next = PH_FINAL;
                    status_res = ST_NOTDICT;
                end
            end
            PH_STRUCT:
            begin
                span = 1'b1;
                if (b == CH_D || b == CH_L)
                begin
                    if (depth_reg == '1)
                    begin
                        phase_next = PH_FINAL;
                        status_res = ST_DEPTH;
                        span       = 1'b0;
                    end
                    else
                        depth_next = depth_reg + DEPTH_BITS'(1);
                end
                else if (b == CH_E)
                begin
                    depth_next = depth_dec;
                    if (depth_dec == '0)
                    begin
                        span_end   = 1'b1;
                        phase_next = PH_FINAL;
                        status_res = ST_DONE;
                    end
                end
                else if (is_digit)
                begin
                    count_next = LEN_BITS'(b[3:0]);
                    phase_next = PH_LEN;
                end
                else if (b == CH_I)
                    phase_next = PH_INT;
                else
                begin
                    phase_next = PH_FINAL;
                    status_res = ST_BADCHAR;
                    span       = 1'b0;
                end
            end
            PH_LEN, PH_LEN_SKIP:
            begin
                span = 1'b1;
                if (b == CH_COLON)
                    phase_next = (count_reg == '0) ? PH_STRUCT : PH_BODY;
                else if (phase_reg == PH_LEN && is_digit)
                begin
                    if (acc[AccW-1:LEN_BITS] != 4'd0)
                    begin
                        phase_next = PH_FINAL;
                        status_res = ST_BADSTR;
                        span       = 1'b0;
                    end
                    else
                        count_next = acc[LEN_BITS-1:0];
                end
                else
                    phase_next = PH_LEN_SKIP;
            end
            PH_BODY:
            begin
                span = 1'b1;
                if (count_reg != '0)
                    count_next = count_reg - LEN_BITS'(1);
                if (count_reg <= LEN_BITS'(1))
                    phase_next = PH_STRUCT;
            end
            PH_INT:
            begin
                span = 1'b1;
                if (b == CH_E)
                    phase_next = PH_STRUCT;
            end
            default:
            begin
            end
        endcase

        // end of file while the scan is still open
        if (word.last_byte && phase_next != PH_FINAL)
        begin
            case (phase_next)
                PH_SEARCH:           status_res = ST_NOKEY;
                PH_EXPECT_D:         status_res = ST_NOTDICT;
                PH_LEN, PH_LEN_SKIP: status_res = ST_BADSTR;
                PH_INT:              status_res = ST_BADINT;
                default:             status_res = ST_TRUNC;
            endcase
            phase_next = PH_FINAL;
            span       = 1'b0;
        end
        status_next = status_res;

        result.byte_out = b;
        result.in_span  = span;
        result.span_end = span_end;
        result.status   = status_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            key_match_reg <= '0;
            depth_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= ST_SEARCH;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                // rearm for the next file
                phase_reg     <= PH_SEARCH;
                key_match_reg <= '0;
                depth_reg     <= '0;
                count_reg     <= '0;
                status_reg    <= ST_SEARCH;
            end
            else
            begin
                phase_reg     <= phase_next;
                key_match_reg <= key_match_next;
                depth_reg     <= depth_next;
                count_reg     <= count_next;
                status_reg    <= status_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bencode_info_span_scanner_top.sv -----
// Top level of the info dictionary span scanner: input register, scan core, result register.
`timescale 1ns / 1ps
`default_nettype none
// Streams a bencoded file one byte per word and marks the bytes of the
// dictionary stored under the first "4:info" key. Each result word carries the
// byte back, an in-span flag, a flag on the dictionary's closing 'e' and a
// status code (search, inside, done, or an error such as missing key, missing
// dictionary, bad string, bad integer, bad character, truncated file or nesting
// too deep). Errors and done hold until the word flagged last_byte, after which
// the scanner rearms for the next file. Throughput is one byte per clock while
// mark_stall stays low: the whole state update for a byte is a single pass of
// logic between the input register and the result register, so the result
// word is offered from the result register once its byte leaves the input
// register. LEN_BITS sets the string length counter (longer lengths are
// reported as bad strings) and DEPTH_BITS the nesting counter (deeper nesting
// is reported as depth overflow). The result register lets a new byte enter
// while a finished word still waits downstream.
module bencode_info_span_scanner_top
    import bisc_pkg::*;
#(
    parameter int LEN_BITS   = 32,
    parameter int DEPTH_BITS = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_word_t byte_word,
    output logic          mark_valid,
    input  wire logic     mark_stall,
    output out_word_t     mark_word
);

    logic      s1_valid_reg;
    in_word_t  s1_word_reg;
    logic      s2_valid_reg;
    out_word_t s2_word_reg;
    out_word_t result;
    logic      advance;
    logic      load;

    // a byte moves to the result register when that register is free or drains
    assign advance    = s1_valid_reg && (!s2_valid_reg || !mark_stall);
    assign byte_stall = s1_valid_reg && !advance;
    assign load       = byte_valid && !byte_stall;

    bisc_scan_core #(
        .LEN_BITS   (LEN_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (s1_word_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= load || (s1_valid_reg && !advance);
            if (advance)
                s2_valid_reg <= 1'b1;
            else if (!mark_stall)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_word_reg <= byte_word;
        if (advance)
            s2_word_reg <= result;
    end

    assign mark_valid = s2_valid_reg;
    assign mark_word  = s2_word_reg;

`ifndef SYNTH
    // closing 'e' is always marked in span and reported done
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && mark_word.span_end |-> mark_word.in_span && mark_word.status == ST_DONE)
        else $error("span_end without done status");

    // error codes never mark the byte
    a_err_no_span: assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid && mark_word.status >= ST_NOKEY |-> !mark_word.in_span)
        else $error("in_span set on an error word");

    // result byte is the byte that advanced
    a_pass_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> mark_word.byte_out == $past(s1_word_reg.data_byte))
        else $error("byte_out does not match input byte");

    // input only stalls while the input register holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> s1_valid_reg && s2_valid_reg)
        else $error("stall with room in the pipeline");
`endif

endmodule
`default_nettype wire
